[rtl/qtrp_pkg.sv]
// Shared types, codes and helpers for the quarter-turn rotator planner.
// No dependencies.
`timescale 1ns / 1ps

package qtrp_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned RevW   = 24;
  localparam int unsigned DivW   = 33;
  localparam int unsigned CntW   = 6;
  localparam int unsigned AngW   = 9;
  localparam int unsigned DistW  = 25;
  localparam int unsigned TgtW   = 33;
  localparam int unsigned IntW   = 23;
  localparam int unsigned ColW   = 32;
  localparam int unsigned MsPerS = 1000;
  localparam int unsigned Deg    = 360;

  typedef enum logic [1:0] {
    REQ_AUTO = 2'd0,
    REQ_GOTO = 2'd1,
    REQ_STEP = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_COUNTS   = 3'd0,
    CFG_AUTO_EN  = 3'd1,
    CFG_STEP_FWD = 3'd2,
    CFG_INTERVAL = 3'd3,
    CFG_COL_0    = 3'd4,
    CFG_COL_90   = 3'd5,
    CFG_COL_180  = 3'd6,
    CFG_COL_270  = 3'd7
  } cfg_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MOD   = 9'b000000010,
    S_NORM  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_ANG   = 9'b000010000,
    S_PICK  = 9'b000100000,
    S_OFF   = 9'b001000000,
    S_FIX   = 9'b010000000,
    S_SHORT = 9'b100000000
  } state_e;

  // snap to nearest quarter, then one quarter forward or back
  function automatic logic [AngW-1:0] next_quarter(input logic [AngW-1:0] cur,
                                                   input logic fwd);
    logic [1:0] qi;
    logic [1:0] qn;
    logic [AngW-1:0] res;
    if (cur < 9'd45)       qi = 2'd0;
    else if (cur < 9'd135) qi = 2'd1;
    else if (cur < 9'd225) qi = 2'd2;
    else if (cur < 9'd315) qi = 2'd3;
    else                   qi = 2'd0;
    qn = fwd ? qi + 2'd1 : qi - 2'd1;
    case (qn)
      2'd0:    res = 9'd0;
      2'd1:    res = 9'd90;
      2'd2:    res = 9'd180;
      default: res = 9'd270;
    endcase
    return res;
  endfunction

endpackage

[rtl/qtrp_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle while step_i is high.
// Depends on qtrp_pkg.
`timescale 1ns / 1ps

module qtrp_div
  import qtrp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic            step_i,
  input  logic [RevW-1:0] divisor_i,
  output logic [DivW-1:0] quo_o,
  output logic [RevW-1:0] rem_o
);

  logic [DivW-1:0] dq_q, dq_d;
  logic [RevW-1:0] rem_q, rem_d;
  logic [RevW:0]   trial;
  logic            ge;

  assign trial = {rem_q, dq_q[DivW-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    if (load_i) begin
      dq_d  = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      dq_d  = {dq_q[DivW-2:0], ge};
      rem_d = ge ? RevW'(trial - {1'b0, divisor_i}) : trial[RevW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_q  <= '0;
      rem_q <= '0;
    end else begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = dq_q;
  assign rem_o = rem_q;

endmodule

[rtl/quarter_turn_rotator_planner_top.sv]
// Quarter-turn rotator planner top level: sequencer, registers, output stage.
// Depends on qtrp_pkg and qtrp_div.
`timescale 1ns / 1ps

// One item in, one result out. An item that issues a move runs from accept to
// result through three passes of the shared bit-serial divider (position mod
// revolution, position to angle, angle to position) and five steps: normalise,
// multiply, pick, fix-up and output. An item that issues no move skips the third
// pass and its fix-up. A result waiting on out_ready_i holds the sequencer
// in its last step. The next item is taken in the cycle after the previous result
// is registered, even if that result has not yet been taken.
module quarter_turn_rotator_planner_top
  import qtrp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [ColW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [PosW-1:0]  encoder_position_i,
  input  logic [AngW-1:0]         goal_angle_i,
  input  logic [31:0]             now_ms_i,
  input  logic                    motion_busy_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    move_valid_o,
  output logic signed [TgtW-1:0]  move_target_o,
  output logic signed [DistW-1:0] move_distance_o,
  output logic [AngW-1:0]         move_angle_o,
  output logic [AngW-1:0]         present_angle_o,
  output logic                    color_valid_o,
  output logic [ColW-1:0]         color_word_o
);

  // configuration
  logic [RevW-1:0] counts_q;
  logic            auto_en_q, step_fwd_q;
  logic [IntW-1:0] interval_q;
  logic [ColW-1:0] col0_q, col90_q, col180_q, col270_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q   <= '0;
      auto_en_q  <= 1'b0;
      step_fwd_q <= 1'b1;
      interval_q <= IntW'(60);
      col0_q     <= '0;
      col90_q    <= '0;
      col180_q   <= '0;
      col270_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_COUNTS:   counts_q   <= cfg_wdata_i[RevW-1:0];
        CFG_AUTO_EN:  auto_en_q  <= cfg_wdata_i[0];
        CFG_STEP_FWD: step_fwd_q <= cfg_wdata_i[0];
        CFG_INTERVAL: interval_q <= cfg_wdata_i[IntW-1:0];
        CFG_COL_0:    col0_q     <= cfg_wdata_i;
        CFG_COL_90:   col90_q    <= cfg_wdata_i;
        CFG_COL_180:  col180_q   <= cfg_wdata_i;
        CFG_COL_270:  col270_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      req_q;
  logic [PosW-1:0] pos_q;
  logic [AngW-1:0] goal_q;
  logic [31:0]     now_q, elapsed_q, last_q;
  logic            busy_q, neg_q, move_q;
  logic [RevW-1:0] norm_q, off_q;
  logic [AngW-1:0] cur_q, ang_q;
  logic [DistW-1:0] dist_w;

  logic            accept, cal;
  logic            div_load, div_step;
  logic [DivW-1:0] div_in, quo;
  logic [RevW-1:0] divisor, rem;
  logic [DivW-1:0] pos_x, pos_abs;

  logic [AngW-1:0] cur_w, ang_w;
  logic            move_w;
  logic [RevW:0]   q_lo;
  logic signed [RevW+1:0] direct;
  logic [RevW+2:0] dbl;
  logic signed [RevW+1:0] cx;
  logic signed [RevW+1:0] pick;

  logic out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign cal        = (counts_q != '0);
  assign out_free   = ~out_valid_o | out_ready_i;

  assign pos_x   = {encoder_position_i[PosW-1], encoder_position_i};
  assign pos_abs = encoder_position_i[PosW-1] ? DivW'(0) - pos_x : pos_x;

  assign divisor  = (state_q == S_OFF) ? RevW'(Deg) : counts_q;
  assign div_step = (state_q == S_MOD) | (state_q == S_ANG) | (state_q == S_OFF);

  assign cur_w  = cal ? quo[AngW-1:0] : '0;
  assign ang_w  = (req_q == REQ_GOTO) ? goal_q : next_quarter(cur_w, step_fwd_q);
  assign move_w = (req_q == REQ_GOTO) | (req_q == REQ_STEP) |
                  ((req_q == REQ_AUTO) & auto_en_q & ~busy_q &
                   ({1'b0, elapsed_q} >= 33'(interval_q) * 33'(MsPerS)));

  always_comb begin
    div_load = 1'b0;
    div_in   = '0;
    unique case (state_q)
      S_IDLE: begin
        div_load = accept;
        div_in   = pos_abs;
      end
      S_MUL: begin
        div_load = 1'b1;
        div_in   = DivW'(norm_q) * DivW'(Deg);
      end
      S_PICK: begin
        div_load = move_w;
        div_in   = DivW'(ang_w) * DivW'(counts_q);
      end
      default: ;
    endcase
  end

  qtrp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i (div_in),
    .step_i     (div_step),
    .divisor_i  (divisor),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // shortest circular distance; direct path wins a tie
  assign q_lo   = quo[RevW:0];
  assign direct = $signed({2'b0, off_q}) - $signed({2'b0, norm_q});
  assign cx     = $signed({2'b0, counts_q});
  always_comb begin
    dbl  = direct[RevW+1] ? (RevW+3)'(-{direct[RevW+1], direct}) << 1
                          : (RevW+3)'({direct[RevW+1], direct}) << 1;
    pick = direct;
    if (dbl > {3'b0, counts_q}) begin
      pick = direct[RevW+1] ? direct + cx : direct - cx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      last_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (accept) begin
          cnt_q   <= CntW'(DivW - 1);
          state_q <= S_MOD;
        end
        S_MOD: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_NORM;
        end
        S_NORM: state_q <= S_MUL;
        S_MUL: begin
          cnt_q   <= CntW'(DivW - 1);
          state_q <= S_ANG;
        end
        S_ANG: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_PICK;
        end
        S_PICK: begin
          cnt_q   <= CntW'(DivW - 1);
          state_q <= move_w ? S_OFF : S_SHORT;
        end
        S_OFF: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_FIX;
        end
        S_FIX: state_q <= S_SHORT;
        S_SHORT: if (out_free) begin
          if (move_q) last_q <= now_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item payload and intermediate values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_type_i;
      pos_q     <= encoder_position_i;
      goal_q    <= goal_angle_i;
      now_q     <= now_ms_i;
      busy_q    <= motion_busy_i;
      neg_q     <= encoder_position_i[PosW-1];
      elapsed_q <= now_ms_i - last_q;
    end
    if (state_q == S_NORM) begin
      norm_q <= !cal ? '0 : (neg_q && rem != '0) ? counts_q - rem : rem;
    end
    if (state_q == S_PICK) begin
      cur_q  <= cur_w;
      ang_q  <= ang_w;
      move_q <= move_w;
      off_q  <= '0;
    end
    if (state_q == S_FIX) begin
      off_q <= !cal ? '0 : (q_lo >= {1'b0, counts_q}) ? RevW'(q_lo - {1'b0, counts_q})
                                                       : q_lo[RevW-1:0];
    end
  end

  always_comb dist_w = cal ? pick[DistW-1:0] : '0;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_SHORT && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SHORT && out_free) begin
      present_angle_o <= cur_q;
      move_valid_o    <= move_q;
      move_angle_o    <= move_q ? ang_q : '0;
      move_distance_o <= move_q ? dist_w : '0;
      move_target_o   <= move_q ? $signed({pos_q[PosW-1], pos_q}) +
                                  $signed({{(TgtW-DistW){dist_w[DistW-1]}}, dist_w})
                                : '0;
      color_valid_o   <= 1'b0;
      color_word_o    <= '0;
      if (move_q) begin
        case (ang_q)
          9'd0:    begin color_valid_o <= 1'b1; color_word_o <= col0_q;   end
          9'd90:   begin color_valid_o <= 1'b1; color_word_o <= col90_q;  end
          9'd180:  begin color_valid_o <= 1'b1; color_word_o <= col180_q; end
          9'd270:  begin color_valid_o <= 1'b1; color_word_o <= col270_q; end
          default: ;
        endcase
      end
    end
  end

endmodule

[bench/tb_quarter_turn_rotator_planner_top.sv]
// Testbench for quarter_turn_rotator_planner_top: drives requests and register
// writes, predicts each result with a scoreboard class. Depends on qtrp_pkg.
`timescale 1ns / 1ps

module tb_quarter_turn_rotator_planner_top;
  import qtrp_pkg::*;

  typedef struct packed {
    logic                    move_valid;
    logic signed [TgtW-1:0]  move_target;
    logic signed [DistW-1:0] move_distance;
    logic [AngW-1:0]         move_angle;
    logic [AngW-1:0]         present_angle;
    logic                    color_valid;
    logic [ColW-1:0]         color_word;
  } plan_t;

  typedef struct packed {
    req_e               req;
    logic signed [31:0] pos;
    logic [AngW-1:0]    goal;
    logic [31:0]        now;
    logic               busy;
  } request_t;

  class rotator_scoreboard;
    logic [RevW-1:0] counts;
    logic            auto_en;
    logic            step_fwd;
    logic [IntW-1:0] interval;
    logic [ColW-1:0] col [4];
    logic [31:0]     last_ms;
    plan_t           plan_q[$];
    int              errors;
    int              moves;
    int              results;

    function new();
      counts = '0; auto_en = 1'b0; step_fwd = 1'b1; interval = 23'd60;
      foreach (col[i]) col[i] = '0;
      last_ms = '0; errors = 0; moves = 0; results = 0;
    endfunction

    function void set_reg(cfg_e idx, logic [31:0] v);
      case (idx)
        CFG_COUNTS:   counts = v[RevW-1:0];
        CFG_AUTO_EN:  auto_en = v[0];
        CFG_STEP_FWD: step_fwd = v[0];
        CFG_INTERVAL: interval = v[IntW-1:0];
        CFG_COL_0:    col[0] = v;
        CFG_COL_90:   col[1] = v;
        CFG_COL_180:  col[2] = v;
        default:      col[3] = v;
      endcase
    endfunction

    function longint wrap_pos(longint ext);
      longint r;
      if (counts == 0) return 0;
      r = ext % longint'(counts);
      if (r < 0) r += longint'(counts);
      return r;
    endfunction

    function int unsigned quarter_after(int unsigned a);
      int unsigned snap;
      snap = ((a + 45) / 90) * 90;
      if (snap >= 360) snap = 0;
      return step_fwd ? (snap + 90) % 360 : (snap + 270) % 360;
    endfunction

    function void fill_move(ref plan_t p, input longint ext, input int unsigned ang,
                            input logic [31:0] now);
      longint c, off, direct, alt, span, ad, aa;
      c = longint'(counts);
      off = (c == 0) ? 0 : (longint'(ang) * c / 360) % c;
      direct = off - wrap_pos(ext);
      alt = (direct > 0) ? direct - c : direct + c;
      ad = (direct < 0) ? -direct : direct;
      aa = (alt < 0) ? -alt : alt;
      span = (c == 0) ? 0 : ((ad <= aa) ? direct : alt);
      p.move_valid = 1'b1;
      p.move_target = TgtW'(ext + span);
      p.move_distance = DistW'(span);
      p.move_angle = AngW'(ang);
      p.color_valid = 1'b1;
      case (ang)
        0:       p.color_word = col[0];
        90:      p.color_word = col[1];
        180:     p.color_word = col[2];
        270:     p.color_word = col[3];
        default: begin
          p.color_valid = 1'b0;
          p.color_word = '0;
        end
      endcase
      last_ms = now;
      moves++;
    endfunction

    function void note_item(request_t r);
      plan_t p;
      longint ext;
      int unsigned cur;
      logic [31:0] elapsed;
      p = '0;
      ext = longint'(r.pos);
      cur = (counts == 0) ? 0 : int'(wrap_pos(ext) * 360 / longint'(counts));
      p.present_angle = AngW'(cur);
      elapsed = (r.now - last_ms) / 32'd1000;
      case (r.req)
        REQ_GOTO: fill_move(p, ext, r.goal, r.now);
        REQ_STEP: fill_move(p, ext, quarter_after(cur), r.now);
        REQ_AUTO: begin
          if (auto_en && !r.busy && elapsed >= 32'(interval))
            fill_move(p, ext, quarter_after(cur), r.now);
        end
        default: ;
      endcase
      plan_q.push_back(p);
    endfunction

    function void check_result(plan_t g);
      plan_t e;
      results++;
      if (plan_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      e = plan_q.pop_front();
      if (g.move_valid !== e.move_valid) begin
        $error("move_valid expected %0d got %0d", e.move_valid, g.move_valid); errors++;
      end
      if (g.move_target !== e.move_target) begin
        $error("move_target expected %0d got %0d", e.move_target, g.move_target); errors++;
      end
      if (g.move_distance !== e.move_distance) begin
        $error("move_distance expected %0d got %0d", e.move_distance, g.move_distance);
        errors++;
      end
      if (g.move_angle !== e.move_angle) begin
        $error("move_angle expected %0d got %0d", e.move_angle, g.move_angle); errors++;
      end
      if (g.present_angle !== e.present_angle) begin
        $error("present_angle expected %0d got %0d", e.present_angle, g.present_angle);
        errors++;
      end
      if (g.color_valid !== e.color_valid) begin
        $error("color_valid expected %0d got %0d", e.color_valid, g.color_valid); errors++;
      end
      if (g.color_word !== e.color_word) begin
        $error("color_word expected %h got %h", e.color_word, g.color_word); errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [2:0]              cfg_index_i;
  logic [ColW-1:0]         cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              req_type_i;
  logic signed [PosW-1:0]  encoder_position_i;
  logic [AngW-1:0]         goal_angle_i;
  logic [31:0]             now_ms_i;
  logic                    motion_busy_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    move_valid_o;
  logic signed [TgtW-1:0]  move_target_o;
  logic signed [DistW-1:0] move_distance_o;
  logic [AngW-1:0]         move_angle_o;
  logic [AngW-1:0]         present_angle_o;
  logic                    color_valid_o;
  logic [ColW-1:0]         color_word_o;

  quarter_turn_rotator_planner_top uut (.*);

  rotator_scoreboard plan_sb = new();
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;
  logic [31:0] clock_ms;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (in_valid_i && in_ready_o)
        plan_sb.note_item('{req_e'(req_type_i), encoder_position_i, goal_angle_i,
                            now_ms_i, motion_busy_i});
      if (out_valid_o && out_ready_i)
        plan_sb.check_result('{move_valid_o, move_target_o, move_distance_o,
                               move_angle_o, present_angle_o, color_valid_o,
                               color_word_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles <= 0;
      else if (quiet_cycles >= 20000) begin
        $display("Simulation FAILED");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_e idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    plan_sb.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= r.req;
    encoder_position_i <= r.pos;
    goal_angle_i <= r.goal;
    now_ms_i <= r.now;
    motion_busy_i <= r.busy;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (plan_sb.plan_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.req = (pick < 35) ? REQ_AUTO : (pick < 65) ? REQ_GOTO : (pick < 93) ? REQ_STEP : REQ_NONE;
    case ($urandom_range(3))
      0:       r.pos = $signed(32'($urandom_range(2000))) - 1000;
      1:       r.pos = $signed(32'($urandom_range(40000000))) - 20000000;
      default: r.pos = $urandom;
    endcase
    r.goal = ($urandom_range(9) == 0) ? AngW'($urandom_range(511)) :
             ($urandom_range(1) ? AngW'(90 * $urandom_range(3)) : AngW'($urandom_range(359)));
    clock_ms += ($urandom_range(9) == 0) ? $urandom : $urandom_range(70000);
    r.now = clock_ms;
    r.busy = ($urandom_range(3) == 0);
    return r;
  endfunction

  task automatic set_phase(logic [23:0] c, logic ae, logic sf, logic [22:0] iv);
    write_reg(CFG_COUNTS, 32'(c));
    write_reg(CFG_AUTO_EN, 32'(ae));
    write_reg(CFG_STEP_FWD, 32'(sf));
    write_reg(CFG_INTERVAL, 32'(iv));
    write_reg(CFG_COL_0, $urandom);
    write_reg(CFG_COL_90, $urandom);
    write_reg(CFG_COL_180, $urandom);
    write_reg(CFG_COL_270, $urandom);
  endtask

  initial begin
    logic [23:0] c_pick [8];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; req_type_i = '0; encoder_position_i = '0;
    goal_angle_i = '0; now_ms_i = '0; motion_busy_i = 1'b0; out_ready_i = 1'b1;
    send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0; clock_ms = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // uncalibrated, reset registers
    send_item('{REQ_GOTO, 32'sh7fffffff, 9'd90, 32'd0, 1'b1});
    send_item('{REQ_STEP, 32'sh80000000, 9'd0, 32'd5, 1'b0});
    send_item('{REQ_AUTO, -32'sd5, 9'd0, 32'd59999, 1'b0});
    drain();

    set_phase(24'd4, 1'b1, 1'b0, 23'd0);
    send_item('{REQ_GOTO, 32'sd0, 9'd180, 32'd10, 1'b0});   // tie, direct path
    send_item('{REQ_GOTO, -32'sd3, 9'd270, 32'd20, 1'b0});
    send_item('{REQ_AUTO, 32'sd1, 9'd0, 32'd30, 1'b1});     // busy blocks
    send_item('{REQ_AUTO, 32'sd1, 9'd0, 32'd30, 1'b0});
    send_item('{REQ_NONE, 32'sd2, 9'd90, 32'd40, 1'b0});
    send_item('{REQ_GOTO, 32'sd2, 9'd511, 32'd50, 1'b0});   // goal past 359
    send_item('{REQ_GOTO, 32'sd2, 9'd360, 32'd60, 1'b0});
    drain();

    set_phase(24'hffffff, 1'b1, 1'b1, 23'd4294967);
    send_item('{REQ_GOTO, 32'sh80000000, 9'd359, 32'd0, 1'b0});
    send_item('{REQ_GOTO, 32'sh7fffffff, 9'd0, 32'd1, 1'b0});
    send_item('{REQ_AUTO, 32'sd100, 9'd0, 32'hffffffff, 1'b0});  // elapsed just past the interval
    send_item('{REQ_STEP, 32'sd8388608, 9'd0, 32'hfffffffe, 1'b0});
    send_item('{REQ_AUTO, 32'sd100, 9'd0, 32'hfffffffd, 1'b0});  // max elapsed
    send_item('{REQ_STEP, -32'sd4194304, 9'd0, 32'd7, 1'b1});
    drain();

    c_pick = '{24'd0, 24'd1, 24'd2, 24'd360, 24'hffffff, 24'd4, 24'd0, 24'd0};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 6) c_pick[ph] = ph[0] ? 24'($urandom) : 24'($urandom_range(3, 5000));
      set_phase(c_pick[ph], ph != 3, ph[0],
                ph == 5 ? 23'd4294967 : 23'($urandom_range(0, 90)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      repeat (60) send_item(random_request());
      drain();
      send_idle_pct = 0; recv_stall_pct = 0;
    end

    $display("Covered %0d results, %0d moves, over eleven register settings", plan_sb.results,
             plan_sb.moves);
    $display("with calibrated, uncalibrated and extreme revolutions and all idling modes.");
    if (plan_sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[quarter_turn_rotator_planner_top.f]
rtl/qtrp_pkg.sv
rtl/qtrp_div.sv
rtl/quarter_turn_rotator_planner_top.sv
bench/tb_quarter_turn_rotator_planner_top.sv
